[rtl/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants of the directional ray dilation block.
// ----------------------------------------------------------------------------
package drd_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_REACH_BITS = 6;

  localparam int CELL_W      = 32;
  localparam int CNT_W       = 7;
  localparam int REACH_REG_W = 4 * DEF_REACH_BITS;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = (REACH_REG_W > CELL_W) ? REACH_REG_W : CELL_W;

  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT        = 3'd0,
    REG_COL_COUNT        = 3'd1,
    REG_MATCH_VALUE      = 3'd2,
    REG_STRAIGHT_REACHES = 3'd3,
    REG_DIAGONAL_REACHES = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        row_count;
    logic [CNT_W-1:0]        col_count;
    logic [CELL_W-1:0]       match_value;
    logic [REACH_REG_W-1:0]  straight_reaches;
    logic [REACH_REG_W-1:0]  diagonal_reaches;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              oor;
  } result_t;

endpackage

[rtl/drd_cfg.sv]
// ----------------------------------------------------------------------------
// drd_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module drd_cfg
  import drd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count        <= ROW_COUNT_RST;
      cfg.col_count        <= COL_COUNT_RST;
      cfg.match_value      <= '0;
      cfg.straight_reaches <= '0;
      cfg.diagonal_reaches <= '0;
    end else if (we) begin
      unique case (index)
        REG_ROW_COUNT:        cfg.row_count        <= data[CNT_W-1:0];
        REG_COL_COUNT:        cfg.col_count        <= data[CNT_W-1:0];
        REG_MATCH_VALUE:      cfg.match_value      <= data[CELL_W-1:0];
        REG_STRAIGHT_REACHES: cfg.straight_reaches <= data[REACH_REG_W-1:0];
        REG_DIAGONAL_REACHES: cfg.diagonal_reaches <= data[REACH_REG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/drd_store.sv]
// ----------------------------------------------------------------------------
// drd_store
// Single-port cell store with registered read data.
// ----------------------------------------------------------------------------
module drd_store
  import drd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [CELL_W-1:0] wdata,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/drd_walker.sv]
// ----------------------------------------------------------------------------
// drd_walker
// Request sequencer: stores writes, walks the eight rays of a read through
// the cell store one cell per cycle along a ray, checking each returned cell.
// ----------------------------------------------------------------------------
module drd_walker
  import drd_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  localparam int DEPTH     = MAX_ROWS * MAX_COLS,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [CELL_W-1:0] in_cell,
  output logic              mem_we,
  output logic              mem_re,
  output logic [AW-1:0]     mem_addr,
  output logic [CELL_W-1:0] mem_wdata,
  input  logic [CELL_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           result
);

  localparam int REACH_BITS = DEF_REACH_BITS;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int PW  = 4 * REACH_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    RAY_LEFT       = 3'd0,
    RAY_RIGHT      = 3'd1,
    RAY_UP         = 3'd2,
    RAY_DOWN       = 3'd3,
    RAY_LEFT_UP    = 3'd4,
    RAY_RIGHT_UP   = 3'd5,
    RAY_LEFT_DOWN  = 3'd6,
    RAY_RIGHT_DOWN = 3'd7
  } ray_t;

  function automatic logic [REACH_BITS-1:0] reach_sel(
    input logic [2:0]             r,
    input logic [REACH_REG_W-1:0] st,
    input logic [REACH_REG_W-1:0] dg
  );
    logic [PW-1:0] pk;
    pk = r[2] ? PW'(dg) : PW'(st);
    return pk[r[1:0]*REACH_BITS +: REACH_BITS];
  endfunction

  function automatic logic [AW-1:0] addr_of(
    input logic [RW-1:0]  r,
    input logic [CLW-1:0] c
  );
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  state_t                state;
  ray_t                  ray;
  logic [REACH_BITS-1:0] rem;
  logic [RW-1:0]         pr;
  logic [CLW-1:0]        pc;
  logic [RW-1:0]         org_r;
  logic [CLW-1:0]        org_c;
  logic                  rd_pend;
  logic                  first;
  logic [CELL_W-1:0]     center;

  logic [RCW-1:0] nr;
  logic [CCW-1:0] nc;
  logic           in_range;
  logic           accept;
  logic           row_inc, row_dec, col_inc, col_dec;
  logic           row_ok, col_ok, can_step, hit_now;
  logic [RW-1:0]  step_r;
  logic [CLW-1:0] step_c;
  ray_t           ray_nxt;

  assign nr = (int'(cfg.row_count) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg.row_count);
  assign nc = (int'(cfg.col_count) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg.col_count);
  assign in_range = (int'(in_row) < int'(nr)) && (int'(in_col) < int'(nc));

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign hit_now   = rd_pend && (mem_rdata == cfg.match_value);
  assign ray_nxt   = ray_t'(ray + 3'd1);

  always_comb begin
    row_inc = 1'b0;
    row_dec = 1'b0;
    col_inc = 1'b0;
    col_dec = 1'b0;
    unique case (ray)
      RAY_LEFT:       col_inc = 1'b1;
      RAY_RIGHT:      col_dec = 1'b1;
      RAY_UP:         row_inc = 1'b1;
      RAY_DOWN:       row_dec = 1'b1;
      RAY_LEFT_UP:    begin row_inc = 1'b1; col_inc = 1'b1; end
      RAY_RIGHT_UP:   begin row_inc = 1'b1; col_dec = 1'b1; end
      RAY_LEFT_DOWN:  begin row_dec = 1'b1; col_inc = 1'b1; end
      RAY_RIGHT_DOWN: begin row_dec = 1'b1; col_dec = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    row_ok = 1'b1;
    col_ok = 1'b1;
    step_r = pr;
    step_c = pc;
    if (row_inc) begin
      row_ok = (int'(pr) + 1) < int'(nr);
      step_r = RW'(pr + 1'b1);
    end else if (row_dec) begin
      row_ok = (pr != '0);
      step_r = RW'(pr - 1'b1);
    end
    if (col_inc) begin
      col_ok = (int'(pc) + 1) < int'(nc);
      step_c = CLW'(pc + 1'b1);
    end else if (col_dec) begin
      col_ok = (pc != '0);
      step_c = CLW'(pc - 1'b1);
    end
  end

  assign can_step = (rem != '0) && row_ok && col_ok;

  always_comb begin
    mem_wdata = in_cell;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_of(step_r, step_c);
    if (state == S_IDLE) begin
      mem_addr = addr_of(RW'(in_row), CLW'(in_col));
      mem_we   = accept && (in_cmd == CMD_WRITE) && in_range;
      mem_re   = accept && (in_cmd == CMD_READ) && in_range;
    end else if (state == S_WALK) begin
      mem_re = can_step && !hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
      unique case (state)
        S_IDLE: begin
          if (accept && (in_cmd == CMD_READ)) begin
            state <= in_range ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          if (hit_now) begin
            state <= S_DONE;
          end else if (!can_step && (ray == RAY_RIGHT_DOWN)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        org_r        <= RW'(in_row);
        org_c        <= CLW'(in_col);
        pr           <= RW'(in_row);
        pc           <= CLW'(in_col);
        ray          <= RAY_LEFT;
        rem          <= reach_sel(RAY_LEFT, cfg.straight_reaches, cfg.diagonal_reaches);
        first        <= 1'b1;
        result.value <= '0;
        result.oor   <= !in_range;
      end
      S_WALK: begin
        if (first) begin
          center <= mem_rdata;
          first  <= 1'b0;
        end
        if (hit_now) begin
          result.value <= cfg.match_value;
        end else if (can_step) begin
          pr  <= step_r;
          pc  <= step_c;
          rem <= REACH_BITS'(rem - 1'b1);
        end else begin
          ray <= ray_nxt;
          pr  <= org_r;
          pc  <= org_c;
          rem <= reach_sel(ray_nxt, cfg.straight_reaches, cfg.diagonal_reaches);
        end
      end
      S_DRAIN: result.value <= hit_now ? cfg.match_value : center;
      S_DONE: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_port_excl: assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("store read and write in the same cycle");
  a_pend_src: assert property (@(posedge clk) disable iff (rst) rd_pend |-> $past(mem_re))
    else $error("read data flagged without an issued read");
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
      (state == S_DONE && result.oor) |-> (result.value == '0))
    else $error("out of range result carries a nonzero cell");
`endif

endmodule

[rtl/directional_ray_dilation.sv]
// ----------------------------------------------------------------------------
// directional_ray_dilation
// Cell store with on-request directional dilation along eight rays.
// ----------------------------------------------------------------------------
// a write request gives no response. a read request walks its eight rays
// through the single-port cell store, one cell read per cycle while it steps
// along a ray, and stops at the first match. without a match the response is
// valid after all eight rays are tested, and the next request is taken once
// the response has moved to the output register; rays stop at the borders,
// so two opposite rays test at most one line less one cell. a match in the
// cell itself ends the read. one request is in flight at a time; a finished
// response waits in the output register while the next request is taken.
// the store has no reset: a cell must be written before a read reaches it.
module directional_ray_dilation
  import drd_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // row, col, cell_in, zero pad
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // cell_out
  output logic                  m_tuser,   // out_of_range
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  result_t           result;

  drd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  drd_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  drd_walker #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_row    (s_tdata[5:0]),
    .in_col    (s_tdata[11:6]),
    .in_cell   (s_tdata[43:12]),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .result    (result)
  );

  assign res_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      m_tdata <= result.value;
      m_tuser <= result.oor;
    end
  end

endmodule
